FILE: rtl/core/i2c_register_access_sequencer_assert.svh
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_assert.svh
// Assertion macros shared by the sequencer's checker.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define RAS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// Next-cycle implication, disabled while rst is high
`define RAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

FILE: rtl/core/i2c_ras_pkg.sv
// ----------------------------------------------------------------------------
// i2c_ras_pkg
// Types and codes for the I2C register access sequencer.
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

   // Command and event codes on the request channel
   localparam logic [2:0] FUNC_READ_BYTE  = 3'd0;
   localparam logic [2:0] FUNC_WRITE      = 3'd1;
   localparam logic [2:0] FUNC_READ_WORD  = 3'd2;
   localparam logic [2:0] FUNC_BUS_DONE   = 3'd3;
   localparam logic [2:0] FUNC_DELAY_DONE = 3'd4;

   // Bus actions on the response channel
   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_SEND  = 3'd1;
   localparam logic [2:0] ACT_RACK  = 3'd2;
   localparam logic [2:0] ACT_RNACK = 3'd3;
   localparam logic [2:0] ACT_STOP  = 3'd4;
   localparam logic [2:0] ACT_WAIT  = 3'd5;
   localparam logic [2:0] ACT_DONE  = 3'd6;

   // Completion error codes
   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_START      = 3'd1;
   localparam logic [2:0] ERR_ADDR_WRITE = 3'd2;
   localparam logic [2:0] ERR_REG        = 3'd3;
   localparam logic [2:0] ERR_DATA       = 3'd4;
   localparam logic [2:0] ERR_ADDR_READ  = 3'd5;
   localparam logic [2:0] ERR_VERIFY     = 3'd6;

   // Bus engine status codes (after masking)
   localparam logic [7:0] ST_START   = 8'h08;
   localparam logic [7:0] ST_SLA_ACK = 8'h18;
   localparam logic [7:0] ST_DAT_ACK = 8'h28;
   localparam logic [7:0] ST_SLR_ACK = 8'h40;
   localparam logic [7:0] ST_MASK    = 8'hf8;

   // Register map and reset values
   localparam logic [0:0] REG_DEVICE_ADDRESS = 1'b0;
   localparam logic [0:0] REG_SETTLE_DELAY   = 1'b1;
   localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h60;
   localparam logic [7:0] SETTLE_DELAY_RST   = 8'd30;

   // Result queue depth (one item can produce two results)
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  tx_byte;
      logic [7:0]  wait_ms;
      logic [15:0] result_data;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

endpackage

FILE: rtl/core/i2c_register_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// Register read, word read and verified write sequencing over a byte I2C
// master.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries commands (read byte, write with verify, read word)
//   and completion events from the bus engine (bus done, delay done).
//   rsp channel carries bus actions (start, send, receive, stop, wait) and a
//   final finished action with read data and an error code.
//   APB port sets the device address and the settle delay between the write
//   and its readback; write it only while no sequence is running.
// Results: the results of an accepted request are registered into the queue, a
//   second result, where there is one, right behind the first; each is offered once the results ahead of it are taken.
// Throughput: one request per cycle. Results wait in a four-entry queue;
//   req_stall rises when fewer than two entries are free, so the rate is
//   set by how fast the receiver drains rsp.
// Reset clears the sequence state, empties the queue and restores the
//   register reset values. While rsp_stall is high the offered result holds
//   and requests keep being taken until fewer than two queue entries are free.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer #(
   parameter int RspDepth = i2c_ras_pkg::RSP_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  i2c_ras_pkg::req_type req_item,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output i2c_ras_pkg::rsp_type rsp_item,
   // configuration port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import i2c_ras_pkg::*;

   localparam int PtrW = $clog2(RspDepth);
   localparam int CntW = $clog2(RspDepth + 1);
   localparam logic [CntW-1:0] AcceptMax = CntW'(RspDepth - 2);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_ADDRW, PH_REG, PH_DATA, PH_DELAY, PH_RSTART,
      PH_ADDRR, PH_RX1, PH_RX2, PH_VSTART, PH_VADDRW, PH_VREG
   } phase_type;

   // sequence state
   phase_type  phase_ff, phase_in;
   logic [1:0] oper_ff, oper_in;
   logic [7:0] saved_reg_ff, saved_reg_in;
   logic [7:0] saved_data_ff, saved_data_in;
   logic [7:0] low_byte_ff, low_byte_in;

   // configuration registers
   logic [6:0] dev_addr_ff;
   logic [7:0] settle_ff;

   // result queue
   rsp_type             rsp_q_ff [RspDepth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   logic       req_xfer, rsp_xfer, cfg_wr;
   logic [1:0] n_res;
   rsp_type    res0, res1;
   logic [7:0] st, addr_w;

   function automatic rsp_type mk(logic [2:0] act, logic [7:0] tx, logic [7:0] wt,
                                  logic [15:0] data, logic [2:0] err, logic lst);
      rsp_type r;
      r.action      = act;
      r.tx_byte     = tx;
      r.wait_ms     = wt;
      r.result_data = data;
      r.error_code  = err;
      r.last        = lst;
      return r;
   endfunction

   assign req_stall = (count_ff > AcceptMax);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign rsp_item  = rsp_q_ff[rd_ptr_ff];

   assign st     = req_item.bus_status & ST_MASK;
   assign addr_w = {dev_addr_ff, 1'b0};

   // next state and results for one request
   always_comb begin
      phase_in      = phase_ff;
      oper_in       = oper_ff;
      saved_reg_in  = saved_reg_ff;
      saved_data_in = saved_data_ff;
      low_byte_in   = low_byte_ff;
      n_res         = 2'd0;
      res0          = mk(ACT_START, 8'd0, 8'd0, 16'd0, ERR_OK, 1'b1);
      res1          = mk(ACT_DONE, 8'd0, 8'd0, 16'd0, ERR_OK, 1'b1);

      if (req_item.func == FUNC_READ_BYTE || req_item.func == FUNC_WRITE ||
          req_item.func == FUNC_READ_WORD) begin
         // new command, taken only when idle
         if (phase_ff == PH_IDLE) begin
            oper_in      = req_item.func[1:0];
            saved_reg_in = req_item.reg_addr;
            if (req_item.func == FUNC_WRITE) begin
               saved_data_in = req_item.write_data;
            end
            n_res    = 2'd1;
            phase_in = PH_START;
         end
      end else if (req_item.func == FUNC_DELAY_DONE) begin
         if (phase_ff == PH_DELAY) begin
            n_res    = 2'd1;
            phase_in = PH_VSTART;
         end
      end else if (req_item.func == FUNC_BUS_DONE) begin
         // stop result used by every failing or closing step
         res0 = mk(ACT_STOP, 8'd0, 8'd0, 16'd0, ERR_OK, 1'b0);
         unique case (phase_ff)
            PH_START: begin
               if (oper_ff != FUNC_READ_WORD[1:0] && st != ST_START) begin
                  n_res = 2'd2; res1.error_code = ERR_START; phase_in = PH_IDLE;
               end else begin
                  n_res = 2'd1; res0 = mk(ACT_SEND, addr_w, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_ADDRW;
               end
            end
            PH_ADDRW: begin
               if (st != ST_SLA_ACK) begin
                  n_res = 2'd2; res1.error_code = ERR_ADDR_WRITE; phase_in = PH_IDLE;
               end else begin
                  n_res = 2'd1;
                  res0 = mk(ACT_SEND, saved_reg_ff, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_REG;
               end
            end
            PH_REG: begin
               n_res = 2'd1;
               if (st != ST_DAT_ACK) begin
                  n_res = 2'd2; res1.error_code = ERR_REG; phase_in = PH_IDLE;
               end else if (oper_ff == FUNC_WRITE[1:0]) begin
                  res0 = mk(ACT_SEND, saved_data_ff, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_DATA;
               end else begin
                  res0 = mk(ACT_START, 8'd0, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_RSTART;
               end
            end
            PH_DATA: begin
               n_res = 2'd2;
               if (st != ST_DAT_ACK) begin
                  res1.error_code = ERR_DATA; phase_in = PH_IDLE;
               end else begin
                  res1 = mk(ACT_WAIT, 8'd0, settle_ff, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_DELAY;
               end
            end
            PH_VSTART: begin
               if (st != ST_START) begin
                  n_res = 2'd2; res1.error_code = ERR_START; phase_in = PH_IDLE;
               end else begin
                  n_res = 2'd1; res0 = mk(ACT_SEND, addr_w, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_VADDRW;
               end
            end
            PH_VADDRW: begin
               if (st != ST_SLA_ACK) begin
                  n_res = 2'd2; res1.error_code = ERR_VERIFY; phase_in = PH_IDLE;
               end else begin
                  n_res = 2'd1;
                  res0 = mk(ACT_SEND, saved_reg_ff, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_VREG;
               end
            end
            PH_VREG: begin
               if (st != ST_DAT_ACK) begin
                  n_res = 2'd2; res1.error_code = ERR_VERIFY; phase_in = PH_IDLE;
               end else begin
                  n_res = 2'd1; res0 = mk(ACT_START, 8'd0, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_RSTART;
               end
            end
            PH_RSTART: begin
               // repeated start status is not checked
               n_res = 2'd1;
               res0 = mk(ACT_SEND, addr_w | 8'h01, 8'd0, 16'd0, ERR_OK, 1'b1);
               phase_in = PH_ADDRR;
            end
            PH_ADDRR: begin
               if (st != ST_SLR_ACK) begin
                  n_res = 2'd2;
                  res1.error_code = (oper_ff == FUNC_WRITE[1:0]) ? ERR_VERIFY
                                                                  : ERR_ADDR_READ;
                  phase_in = PH_IDLE;
               end else begin
                  n_res = 2'd1;
                  res0 = mk((oper_ff == FUNC_READ_WORD[1:0]) ? ACT_RACK : ACT_RNACK,
                            8'd0, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_RX1;
               end
            end
            PH_RX1: begin
               if (oper_ff == FUNC_READ_WORD[1:0]) begin
                  n_res = 2'd1;
                  low_byte_in = req_item.rx_byte;
                  res0 = mk(ACT_RNACK, 8'd0, 8'd0, 16'd0, ERR_OK, 1'b1);
                  phase_in = PH_RX2;
               end else begin
                  n_res = 2'd2;
                  res1.result_data = {8'd0, req_item.rx_byte};
                  phase_in = PH_IDLE;
               end
            end
            PH_RX2: begin
               n_res = 2'd2;
               res1.result_data = {req_item.rx_byte, low_byte_ff};
               phase_in = PH_IDLE;
            end
            PH_IDLE, PH_DELAY: begin
               n_res = 2'd0;
            end
            default: begin
               n_res = 2'd0;
            end
         endcase
      end
   end

   // sequence state, queue control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         oper_ff       <= 2'd0;
         saved_reg_ff  <= 8'd0;
         saved_data_ff <= 8'd0;
         low_byte_ff   <= 8'd0;
         dev_addr_ff   <= DEVICE_ADDRESS_RST;
         settle_ff     <= SETTLE_DELAY_RST;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_xfer) begin
            phase_ff      <= phase_in;
            oper_ff       <= oper_in;
            saved_reg_ff  <= saved_reg_in;
            saved_data_ff <= saved_data_in;
            low_byte_ff   <= low_byte_in;
            wr_ptr_ff     <= wr_ptr_ff + PtrW'(n_res);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_ff + (req_xfer ? CntW'(n_res) : CntW'(0))
                              - (rsp_xfer ? CntW'(1) : CntW'(0));
         if (cfg_wr) begin
            if (paddr[2] == REG_DEVICE_ADDRESS) begin
               dev_addr_ff <= pwdata[6:0];
            end else begin
               settle_ff <= pwdata[7:0];
            end
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_xfer && n_res != 2'd0) begin
         rsp_q_ff[wr_ptr_ff] <= res0;
      end
      if (req_xfer && n_res == 2'd2) begin
         rsp_q_ff[wr_ptr_ff + PtrW'(1)] <= res1;
      end
   end

   // APB register access
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   always_comb begin
      if (paddr[2] == REG_DEVICE_ADDRESS) begin
         prdata = {25'd0, dev_addr_ff};
      end else begin
         prdata = {24'd0, settle_ff};
      end
   end

endmodule

FILE: rtl/core/i2c_ras_checker.sv
// ----------------------------------------------------------------------------
// i2c_ras_checker
// Port-level checks for the I2C register access sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "i2c_register_access_sequencer_assert.svh"

module i2c_ras_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input i2c_ras_pkg::rsp_type rsp_item
);
   import i2c_ras_pkg::*;

   // queue is empty right after reset
   `RAS_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid)

   // a stalled result holds
   `RAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // a stop is always followed by its finish or wait, already queued
   `RAS_ASSERT_NEXT(a_stop_pair, clock, reset, rsp_valid && !rsp_stall && rsp_item.action == ACT_STOP, rsp_valid)

   // finish closes the sequence step, stop never does
   `RAS_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, rsp_item.last == (rsp_item.action != ACT_STOP))

   // error codes only appear on a finish
   `RAS_ASSERT_NOW(a_err_on_done, clock, reset, rsp_valid && rsp_item.error_code != ERR_OK, rsp_item.action == ACT_DONE)

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_i2c_ras_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C register access sequencer. A software
// model of the bus sequencing tracks every accepted request and queues the
// bus actions it should cause; each response transfer is checked field by
// field against the oldest queued action. Directed sequences cover the word
// read, the verified write and ignored events; random traffic then runs
// well-formed transactions with occasional bad bus status and noise, under
// three idle and stall patterns and several register settings.
// ----------------------------------------------------------------------------
module tb;
   import i2c_ras_pkg::*;

   localparam int HOLD_OFF       = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_GOAL    = 360;
   localparam int BAD_STATUS_PCT = 5;

   // Sequencer phases tracked by the model
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_START, SEQ_ADDR_WR, SEQ_REG, SEQ_DATA, SEQ_SETTLE,
      SEQ_RESTART, SEQ_ADDR_RD, SEQ_RX_FIRST, SEQ_RX_SECOND,
      SEQ_VFY_START, SEQ_VFY_ADDR, SEQ_VFY_REG
   } seq_state_type;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_item  = '0;
   logic        rsp_stall = 1'b0;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic [31:0] prdata;
   logic        pready;

   // Model state and configuration
   seq_state_type seq_phase  = SEQ_IDLE;
   logic [2:0]  seq_op       = FUNC_READ_BYTE;
   logic [7:0]  seq_reg      = '0;
   logic [7:0]  seq_data     = '0;
   logic [7:0]  seq_low      = '0;
   logic [6:0]  cfg_dev_addr = DEVICE_ADDRESS_RST;
   logic [7:0]  cfg_settle   = SETTLE_DELAY_RST;

   rsp_type     expected_actions[$];
   rsp_type     oldest_action;

   int req_idle_pct    = 20;
   int rsp_stall_pct   = 20;
   int mismatches      = 0;
   int items_sent      = 0;
   int productive_items = 0;
   int actions_queued  = 0;
   int actions_checked = 0;
   int error_endings   = 0;
   int drain_pauses    = 0;
   int quiet_cycles    = 0;

   i2c_register_access_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   // Failure bookkeeping; only the first ten are printed
   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
   endtask

   // ---------------------------------------------------------------------
   // Sequencer model
   // ---------------------------------------------------------------------
   task automatic push_action(input logic [2:0] act, input logic [7:0] tx,
                              input logic [7:0] wt, input logic [15:0] data,
                              input logic [2:0] err, input logic last);
      rsp_type r;
      r.action      = act;
      r.tx_byte     = tx;
      r.wait_ms     = wt;
      r.result_data = data;
      r.error_code  = err;
      r.last        = last;
      expected_actions.push_back(r);
      actions_queued++;
   endtask

   task automatic end_with_error(input logic [2:0] err);
      push_action(ACT_STOP, 8'h00, 8'h00, 16'h0000, ERR_OK, 1'b0);
      push_action(ACT_DONE, 8'h00, 8'h00, 16'h0000, err, 1'b1);
      seq_phase = SEQ_IDLE;
      error_endings++;
   endtask

   task automatic end_with_data(input logic [15:0] data);
      push_action(ACT_STOP, 8'h00, 8'h00, 16'h0000, ERR_OK, 1'b0);
      push_action(ACT_DONE, 8'h00, 8'h00, data, ERR_OK, 1'b1);
      seq_phase = SEQ_IDLE;
   endtask

   task automatic send_byte(input logic [7:0] b, input seq_state_type next);
      push_action(ACT_SEND, b, 8'h00, 16'h0000, ERR_OK, 1'b1);
      seq_phase = next;
   endtask

   task automatic issue_start(input seq_state_type next);
      push_action(ACT_START, 8'h00, 8'h00, 16'h0000, ERR_OK, 1'b1);
      seq_phase = next;
   endtask

   // Work out the actions caused by one accepted request
   task automatic predict_sequencer(input req_type it);
      logic [7:0] status;
      logic [7:0] addr_wr;
      int         queued_before;
      status        = it.bus_status & ST_MASK;
      addr_wr       = {cfg_dev_addr, 1'b0};
      queued_before = actions_queued;
      if (it.func <= FUNC_READ_WORD) begin
         // commands are taken only while idle
         if (seq_phase == SEQ_IDLE) begin
            seq_op  = it.func;
            seq_reg = it.reg_addr;
            if (it.func == FUNC_WRITE) seq_data = it.write_data;
            issue_start(SEQ_START);
         end
      end else if (it.func == FUNC_BUS_DONE) begin
         case (seq_phase)
            SEQ_START: begin
               // word read never checks its first start
               if (seq_op != FUNC_READ_WORD && status != ST_START)
                  end_with_error(ERR_START);
               else
                  send_byte(addr_wr, SEQ_ADDR_WR);
            end
            SEQ_ADDR_WR: begin
               if (status != ST_SLA_ACK) end_with_error(ERR_ADDR_WRITE);
               else send_byte(seq_reg, SEQ_REG);
            end
            SEQ_REG: begin
               if (status != ST_DAT_ACK) end_with_error(ERR_REG);
               else if (seq_op == FUNC_WRITE) send_byte(seq_data, SEQ_DATA);
               else issue_start(SEQ_RESTART);
            end
            SEQ_DATA: begin
               if (status != ST_DAT_ACK) begin
                  end_with_error(ERR_DATA);
               end else begin
                  push_action(ACT_STOP, 8'h00, 8'h00, 16'h0000, ERR_OK, 1'b0);
                  push_action(ACT_WAIT, 8'h00, cfg_settle, 16'h0000, ERR_OK, 1'b1);
                  seq_phase = SEQ_SETTLE;
               end
            end
            SEQ_VFY_START: begin
               if (status != ST_START) end_with_error(ERR_START);
               else send_byte(addr_wr, SEQ_VFY_ADDR);
            end
            SEQ_VFY_ADDR: begin
               if (status != ST_SLA_ACK) end_with_error(ERR_VERIFY);
               else send_byte(seq_reg, SEQ_VFY_REG);
            end
            SEQ_VFY_REG: begin
               if (status != ST_DAT_ACK) end_with_error(ERR_VERIFY);
               else issue_start(SEQ_RESTART);
            end
            // repeated start status is never checked
            SEQ_RESTART: send_byte(addr_wr | 8'h01, SEQ_ADDR_RD);
            SEQ_ADDR_RD: begin
               if (status != ST_SLR_ACK) begin
                  end_with_error(seq_op == FUNC_WRITE ? ERR_VERIFY : ERR_ADDR_READ);
               end else begin
                  push_action(seq_op == FUNC_READ_WORD ? ACT_RACK : ACT_RNACK,
                              8'h00, 8'h00, 16'h0000, ERR_OK, 1'b1);
                  seq_phase = SEQ_RX_FIRST;
               end
            end
            SEQ_RX_FIRST: begin
               if (seq_op == FUNC_READ_WORD) begin
                  seq_low = it.rx_byte;
                  push_action(ACT_RNACK, 8'h00, 8'h00, 16'h0000, ERR_OK, 1'b1);
                  seq_phase = SEQ_RX_SECOND;
               end else begin
                  end_with_data({8'h00, it.rx_byte});
               end
            end
            SEQ_RX_SECOND: end_with_data({it.rx_byte, seq_low});
            default: ;
         endcase
      end else if (it.func == FUNC_DELAY_DONE && seq_phase == SEQ_SETTLE) begin
         issue_start(SEQ_VFY_START);
      end
      if (actions_queued != queued_before) productive_items++;
   endtask

   // Status the bus engine reports on success in a given phase
   function automatic logic [7:0] good_status(input seq_state_type p);
      case (p)
         SEQ_START, SEQ_VFY_START:          good_status = ST_START;
         SEQ_ADDR_WR, SEQ_VFY_ADDR:         good_status = ST_SLA_ACK;
         SEQ_REG, SEQ_DATA, SEQ_VFY_REG:    good_status = ST_DAT_ACK;
         SEQ_ADDR_RD:                       good_status = ST_SLR_ACK;
         default:                           good_status = 8'($urandom_range(255));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // One request transfer, with random idle cycles in front of it
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      predict_sequencer(it);
   endtask

   task automatic send_fields(input logic [2:0] func, input logic [7:0] reg_addr,
                              input logic [7:0] wdata, input logic [7:0] status,
                              input logic [7:0] rx);
      req_type it;
      it.func       = func;
      it.reg_addr   = reg_addr;
      it.write_data = wdata;
      it.bus_status = status;
      it.rx_byte    = rx;
      send_item(it);
   endtask

   // Sender holds off until every queued action has been seen
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_actions.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   task automatic write_register(input logic [0:0] idx, input logic [7:0] value);
      logic [31:0] data;
      data = $urandom;
      if (idx == REG_DEVICE_ADDRESS) data[6:0] = value[6:0];
      else data[7:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_DEVICE_ADDRESS) cfg_dev_addr = data[6:0];
      else cfg_settle = data[7:0];
      @(posedge clock);
   endtask

   task automatic check_register(input logic [0:0] idx);
      logic [31:0] got;
      logic [31:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got     = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_DEVICE_ADDRESS) begin
         got  = got & 32'h7f;
         want = {25'd0, cfg_dev_addr};
      end else begin
         got  = got & 32'hff;
         want = {24'd0, cfg_settle};
      end
      if (got !== want)
         note_failure($sformatf("register %0d read: expected %h, got %h", idx, want, got));
      @(posedge clock);
   endtask

   // Change settings only once the block has gone quiet
   task automatic reconfigure(input logic [6:0] dev, input logic [7:0] settle);
      drain_results();
      repeat (HOLD_OFF) @(posedge clock);
      write_register(REG_DEVICE_ADDRESS, {1'b0, dev});
      write_register(REG_SETTLE_DELAY, settle);
      check_register(REG_DEVICE_ADDRESS);
      check_register(REG_SETTLE_DELAY);
   endtask

   // ---------------------------------------------------------------------
   // Random traffic helpers
   // ---------------------------------------------------------------------
   task automatic send_noise();
      send_fields(3'($urandom_range(7)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
   endtask

   // Answer bus actions until the running transaction has ended
   task automatic drive_to_idle();
      logic [7:0] status;
      while (seq_phase != SEQ_IDLE) begin
         if ($urandom_range(99) < 8) begin
            send_noise();
         end else if (seq_phase == SEQ_SETTLE) begin
            send_fields(FUNC_DELAY_DONE, 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
         end else begin
            if ($urandom_range(99) < BAD_STATUS_PCT) status = 8'($urandom_range(255));
            else status = good_status(seq_phase) | 8'($urandom_range(7));
            send_fields(FUNC_BUS_DONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        status, 8'($urandom_range(255)));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_register_defaults();
      check_register(REG_DEVICE_ADDRESS);
      check_register(REG_SETTLE_DELAY);
   endtask

   // Word read: unchecked first start and repeated start, busy command,
   // reserved func, data extremes
   task automatic test_read_word();
      send_fields(FUNC_READ_WORD, 8'hff, 8'h00, 8'h00, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(3'd7, 8'hff, 8'hff, 8'hff, 8'hff);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h1f, 8'h00);
      send_fields(FUNC_READ_BYTE, 8'h55, 8'haa, 8'h08, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h28, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'hff, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h47, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h00, 8'hff);
      send_fields(FUNC_BUS_DONE, 8'hff, 8'hff, 8'hff, 8'h00);
   endtask

   // Verified write through the settle wait and readback, with stray events
   task automatic test_write_verify();
      send_fields(FUNC_DELAY_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(FUNC_WRITE, 8'h00, 8'hff, 8'h00, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h08, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h18, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h28, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h2b, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h08, 8'h00);
      send_fields(FUNC_DELAY_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h0f, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h18, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h28, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h40, 8'h00);
      send_fields(FUNC_BUS_DONE, 8'h00, 8'h00, 8'h00, 8'h5a);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int stall_pct,
                                      input logic [6:0] dev, input logic [7:0] settle);
      int goal;
      reconfigure(dev, settle);
      req_idle_pct  = sender_pct;
      rsp_stall_pct = stall_pct;
      goal = productive_items + RANDOM_GOAL;
      while (productive_items < goal) begin
         if ($urandom_range(99) < 2) begin
            drain_results();
            drain_pauses++;
         end
         if ($urandom_range(99) < 10)
            send_noise();
         else
            send_fields(3'($urandom_range(2)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
         drive_to_idle();
      end
   endtask

   // ---------------------------------------------------------------------
   // Response checking and receiver stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            actions_checked++;
            if (expected_actions.size() == 0) begin
               note_failure($sformatf("unexpected result act=%0d tx=%h wait=%0d data=%h err=%0d",
                            rsp_item.action, rsp_item.tx_byte, rsp_item.wait_ms,
                            rsp_item.result_data, rsp_item.error_code));
            end else begin
               oldest_action = expected_actions.pop_front();
               if (rsp_item.action !== oldest_action.action ||
                   rsp_item.tx_byte !== oldest_action.tx_byte ||
                   rsp_item.wait_ms !== oldest_action.wait_ms ||
                   rsp_item.result_data !== oldest_action.result_data ||
                   rsp_item.error_code !== oldest_action.error_code ||
                   rsp_item.last !== oldest_action.last)
                  note_failure($sformatf({"result %0d: expected act=%0d tx=%h wait=%0d ",
                               "data=%h err=%0d last=%b, got act=%0d tx=%h wait=%0d ",
                               "data=%h err=%0d last=%b"}, actions_checked,
                               oldest_action.action, oldest_action.tx_byte,
                               oldest_action.wait_ms, oldest_action.result_data,
                               oldest_action.error_code, oldest_action.last,
                               rsp_item.action, rsp_item.tx_byte, rsp_item.wait_ms,
                               rsp_item.result_data, rsp_item.error_code, rsp_item.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_read_word();
      test_write_verify();
      test_random_traffic(33, 79, 7'h00, 8'h00);
      test_random_traffic(79, 33, 7'h7f, 8'hff);
      test_random_traffic(0, 0, 7'($urandom_range(127)), 8'($urandom_range(255)));
      drain_results();
      repeat (HOLD_OFF) @(posedge clock);
      if (expected_actions.size() != 0)
         note_failure($sformatf("%0d expected results never arrived",
                      expected_actions.size()));
      $display("Summary: %0d requests sent, %0d caused bus actions, %0d results checked",
               items_sent, productive_items, actions_checked);
      $display("Summary: %0d error endings, %0d drain pauses, %0d mismatches",
               error_endings, drain_pauses, mismatches);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
